// ----- hw/rtl/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and codes for the UTF-8 decoder: byte classes passed from the
// front end to the back end, and the result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

   // Result status codes
   localparam logic [2:0] ST_CHAR     = 3'd0;
   localparam logic [2:0] ST_BAD_LEAD = 3'd1;
   localparam logic [2:0] ST_BAD_CONT = 3'd2;
   localparam logic [2:0] ST_MID_END  = 3'd3;
   localparam logic [2:0] ST_END      = 3'd4;

   // Byte classes
   localparam logic [2:0] KIND_ZERO     = 3'd0;
   localparam logic [2:0] KIND_ASCII    = 3'd1;
   localparam logic [2:0] KIND_CONT     = 3'd2;
   localparam logic [2:0] KIND_LEAD     = 3'd3;
   localparam logic [2:0] KIND_BAD_LEAD = 3'd4;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // One classified byte
   typedef struct packed {
      logic [2:0] kind;   // byte class
      logic [6:0] data;   // payload bits carried by the byte
      logic [2:0] count;  // continuation bytes announced by a lead
   } byte_class_type;

endpackage

`default_nettype wire

// ----- hw/rtl/utf8_to_codepoint_decoder_core.sv -----
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_core
// Decodes a zero-terminated stream of original UTF-8 (up to six bytes per
// sequence) into 31-bit code points with error and end-of-message status.
//
//   Channel  Direction  Handshake       Payload
//   req      in         push / full     data_byte[7:0]
//   rsp      out        empty / pop     code_point[30:0], status[2:0],
//                                       end_of_message
//
// One byte per cycle sustained while results are popped; the decode step in
// the back end is one shift, OR and count update per beat.
// An accepted byte is registered in the queue, then its result in the result register.
// A two-entry queue between classifier and decoder lets input and output
// stall independently; full rises when both queue entries are occupied.
// Synchronous reset clears the queue, the sequence state and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_codepoint_decoder_core
   import utf8d_pkg::*;
#(
   parameter int MAX_SEQUENCE_BYTES = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [7:0]  req_data_byte,
   output logic             req_full,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [30:0]      rsp_code_point,
   output logic [2:0]       rsp_status,
   output logic             rsp_end_of_message
);

   byte_class_type item;
   logic           item_empty;
   logic           take;

   utf8d_front #(
      .MAX_SEQUENCE_BYTES (MAX_SEQUENCE_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_full      (req_full),
      .take          (take),
      .item          (item),
      .item_empty    (item_empty)
   );

   utf8d_back u_back (
      .clock              (clock),
      .reset              (reset),
      .item               (item),
      .item_empty         (item_empty),
      .take               (take),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_code_point     (rsp_code_point),
      .rsp_status         (rsp_status),
      .rsp_end_of_message (rsp_end_of_message)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/utf8d_queue.sv -----
// ----------------------------------------------------------------------------
// utf8d_queue
// Small register queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_queue
   import utf8d_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire byte_class_type push_item,
   output logic                full,
   input  wire logic           pop,
   output byte_class_type      pop_item,
   output logic                empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

   byte_class_type   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_C);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_C) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_C) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/utf8d_front.sv -----
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts input bytes, classifies each one (end, ASCII, continuation, lead,
// bad lead) and queues the class for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_front
   import utf8d_pkg::*;
#(
   parameter int MAX_SEQUENCE_BYTES = 6
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   input  wire logic [7:0] req_data_byte,
   output logic            req_full,
   input  wire logic       take,
   output byte_class_type  item,
   output logic            item_empty
);

   localparam logic [2:0] MAX_N = 3'(MAX_SEQUENCE_BYTES);

   byte_class_type cls;
   logic [2:0]     ones;

   // Count leading ones of a lead byte; 7 stands for 0xFE and 0xFF
   always_comb begin
      priority if (!req_data_byte[5]) begin
         ones = 3'd2;
      end else if (!req_data_byte[4]) begin
         ones = 3'd3;
      end else if (!req_data_byte[3]) begin
         ones = 3'd4;
      end else if (!req_data_byte[2]) begin
         ones = 3'd5;
      end else if (!req_data_byte[1]) begin
         ones = 3'd6;
      end else begin
         ones = 3'd7;
      end
   end

   // Classify the byte
   always_comb begin
      cls.kind  = KIND_BAD_LEAD;
      cls.data  = '0;
      cls.count = '0;
      priority if (req_data_byte == 8'h00) begin
         cls.kind = KIND_ZERO;
      end else if (!req_data_byte[7]) begin
         cls.kind = KIND_ASCII;
         cls.data = req_data_byte[6:0];
      end else if (!req_data_byte[6]) begin
         cls.kind = KIND_CONT;
         cls.data = {1'b0, req_data_byte[5:0]};
      end else if (ones <= MAX_N) begin
         cls.kind  = KIND_LEAD;
         cls.data  = req_data_byte[6:0] & (7'h7F >> ones);
         cls.count = ones - 3'd1;
      end else begin
         cls.kind = KIND_BAD_LEAD;
      end
   end

   utf8d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (cls),
      .full      (req_full),
      .pop       (take),
      .pop_item  (item),
      .empty     (item_empty)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/utf8d_back.sv -----
// ----------------------------------------------------------------------------
// utf8d_back
// Sequence state machine: gathers continuation bits, detects errors, drops
// bytes after an error and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_back
   import utf8d_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire byte_class_type item,
   input  wire logic           item_empty,
   output logic                take,
   output logic                rsp_empty,
   input  wire logic           rsp_pop,
   output logic [30:0]         rsp_code_point,
   output logic [2:0]          rsp_status,
   output logic                rsp_end_of_message
);

   logic [2:0]  remain_ff, remain_in;
   logic [30:0] partial_ff, partial_in;
   logic        discard_ff, discard_in;
   logic        out_valid_ff, out_valid_in;
   logic [30:0] cp_ff, cp_in;
   logic [2:0]  status_ff, status_in;
   logic        eom_ff, eom_in;
   logic        emit;
   logic [30:0] shifted;

   // Take a queued byte when the result register is free or being drained
   assign take    = !item_empty && (!out_valid_ff || rsp_pop);
   assign shifted = {partial_ff[24:0], item.data[5:0]};

   // Decode step
   always_comb begin
      remain_in  = remain_ff;
      partial_in = partial_ff;
      discard_in = discard_ff;
      emit       = 1'b0;
      cp_in      = '0;
      status_in  = ST_CHAR;
      eom_in     = 1'b0;
      if (take) begin
         priority if (item.kind == KIND_ZERO) begin
            emit       = 1'b1;
            eom_in     = 1'b1;
            status_in  = (remain_ff != '0 && !discard_ff) ? ST_MID_END : ST_END;
            remain_in  = '0;
            partial_in = '0;
            discard_in = 1'b0;
         end else if (discard_ff) begin
            emit = 1'b0;
         end else if (remain_ff != '0) begin
            if (item.kind != KIND_CONT) begin
               emit       = 1'b1;
               status_in  = ST_BAD_CONT;
               remain_in  = '0;
               partial_in = '0;
               discard_in = 1'b1;
            end else if (remain_ff == 3'd1) begin
               emit       = 1'b1;
               cp_in      = shifted;
               remain_in  = '0;
               partial_in = '0;
            end else begin
               remain_in  = remain_ff - 3'd1;
               partial_in = shifted;
            end
         end else begin
            unique case (item.kind)
               KIND_ASCII: begin
                  emit  = 1'b1;
                  cp_in = {24'd0, item.data};
               end
               KIND_LEAD: begin
                  partial_in = {24'd0, item.data};
                  remain_in  = item.count;
               end
               default: begin
                  // stray continuation or bad lead
                  emit       = 1'b1;
                  status_in  = ST_BAD_LEAD;
                  discard_in = 1'b1;
               end
            endcase
         end
      end
   end

   // Result register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff    <= '0;
         partial_ff   <= '0;
         discard_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         remain_ff    <= remain_in;
         partial_ff   <= partial_in;
         discard_ff   <= discard_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         cp_ff     <= cp_in;
         status_ff <= status_in;
         eom_ff    <= eom_in;
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_code_point     = cp_ff;
   assign rsp_status         = status_ff;
   assign rsp_end_of_message = eom_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/utf8d_checker.sv -----
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder: reset state, status consistency and a
// stable result while the consumer stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_checker
   import utf8d_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [30:0] rsp_code_point,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_end_of_message
);

   // Both channels come out of reset idle
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("channels not idle after reset");

   // End marker only with an end status
   a_eom_status: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_end_of_message) |->
         (rsp_status == ST_END || rsp_status == ST_MID_END))
      else $error("end of message with wrong status");

   // Non-end results carry a character or an in-message error
   a_body_status: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_end_of_message) |->
         (rsp_status == ST_CHAR || rsp_status == ST_BAD_LEAD ||
          rsp_status == ST_BAD_CONT))
      else $error("body result with end status");

   // Error and end results carry no code point
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_CHAR) |-> (rsp_code_point == '0))
      else $error("code point set on non-character result");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_code_point) && $stable(rsp_status) &&
          $stable(rsp_end_of_message)))
      else $error("stalled result changed");

endmodule

bind utf8_to_codepoint_decoder_core utf8d_checker u_checker (.*);

`default_nettype wire
